FILE: hw/rtl/si_pkg.sv
// ============================================================================
// si_pkg - shared types and constants for segment_intersection
// Coordinate and fixed point widths, derived datapath widths, result codes.
// ============================================================================
package si_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 16;

    // coordinate difference, product of two differences, determinant
    localparam int DW  = COORD_BITS + 1;
    localparam int PW  = 2 * DW;
    localparam int KW  = PW + 1;
    // magnitude of determinant and normalized numerators
    localparam int MW  = 2 * COORD_BITS + 2;
    // quotient, scaled numerator, dividend, trial remainder
    localparam int QW  = COORD_BITS + FRAC_BITS;
    localparam int NW  = MW + COORD_BITS;
    localparam int DVW = NW + FRAC_BITS;
    localparam int RW  = MW + 1;
    // fixed point coordinate before truncation to the output width
    localparam int VW  = COORD_BITS + FRAC_BITS + 2;
    localparam int OUT_W = 32;

    localparam int IN_TDATA_W  = 8 * COORD_BITS;
    localparam int OUT_TDATA_W = 2 * OUT_W;

    typedef enum logic [1:0] {
        ST_HIT      = 2'd0,
        ST_PARALLEL = 2'd1,
        ST_OUTSIDE  = 2'd2
    } t_status;

    // per-item side information that rides along the divider
    typedef struct packed {
        t_status                       status;
        logic                          neg_x;
        logic                          neg_y;
        logic signed [COORD_BITS-1:0]  base_x;
        logic signed [COORD_BITS-1:0]  base_y;
    } t_side;

    typedef struct packed {
        t_status           status;
        logic [OUT_W-1:0]  cross_x;
        logic [OUT_W-1:0]  cross_y;
    } t_result;

endpackage

FILE: hw/rtl/si_front.sv
// ============================================================================
// si_front - determinant and numerator stages
// Differences, products, determinant, sign normalization and bounds status,
// then scaling of the line parameter by the segment extents.
// ============================================================================
module si_front
    import si_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [IN_TDATA_W-1:0] i_tdata,
    output logic                  o_valid,
    output logic [NW-1:0]         o_num_x,
    output logic [NW-1:0]         o_num_y,
    output logic [MW-1:0]         o_den,
    output t_side                 o_side
);

    logic signed [COORD_BITS-1:0] x1, y1, x2, y2, x3, y3, x4, y4;

    assign x1 = i_tdata[0*COORD_BITS +: COORD_BITS];
    assign y1 = i_tdata[1*COORD_BITS +: COORD_BITS];
    assign x2 = i_tdata[2*COORD_BITS +: COORD_BITS];
    assign y2 = i_tdata[3*COORD_BITS +: COORD_BITS];
    assign x3 = i_tdata[4*COORD_BITS +: COORD_BITS];
    assign y3 = i_tdata[5*COORD_BITS +: COORD_BITS];
    assign x4 = i_tdata[6*COORD_BITS +: COORD_BITS];
    assign y4 = i_tdata[7*COORD_BITS +: COORD_BITS];

    // stage 1: differences
    logic                         r1_valid;
    logic signed [DW-1:0]         r1_a, r1_b, r1_c, r1_e, r1_f, r1_g, r1_dx, r1_dy;
    logic signed [COORD_BITS-1:0] r1_x1, r1_y1;
    // stage 2: products
    logic                         r2_valid;
    logic signed [PW-1:0]         r2_ab, r2_ce, r2_fb, r2_ge, r2_ag, r2_cf;
    logic signed [DW-1:0]         r2_dx, r2_dy;
    logic signed [COORD_BITS-1:0] r2_x1, r2_y1;
    // stage 3: determinant and numerators
    logic                         r3_valid;
    logic signed [KW-1:0]         r3_d, r3_tn, r3_un;
    logic signed [DW-1:0]         r3_dx, r3_dy;
    logic signed [COORD_BITS-1:0] r3_x1, r3_y1;
    // stage 4: normalized values and status
    logic                         r4_valid;
    logic [MW-1:0]                r4_den, r4_tn;
    logic [COORD_BITS-1:0]        r4_mag_x, r4_mag_y;
    t_side                        r4_side;
    // stage 5: scaled numerators
    logic                         r5_valid;
    logic [NW-1:0]                r5_num_x, r5_num_y;
    logic [MW-1:0]                r5_den;
    t_side                        r5_side;

    logic signed [KW-1:0] n4_d, n4_tn, n4_un;
    logic signed [DW-1:0] n4_mx, n4_my;
    t_status              n4_status;

    always_comb begin
        n4_d  = r3_d[KW-1]  ? -r3_d  : r3_d;
        n4_tn = r3_d[KW-1]  ? -r3_tn : r3_tn;
        n4_un = r3_d[KW-1]  ? -r3_un : r3_un;
        n4_mx = r3_dx[DW-1] ? -r3_dx : r3_dx;
        n4_my = r3_dy[DW-1] ? -r3_dy : r3_dy;
        if (r3_d == '0) begin
            n4_status = ST_PARALLEL;
        end else if (n4_tn < 0 || n4_tn > n4_d || n4_un < 0 || n4_un > n4_d) begin
            n4_status = ST_OUTSIDE;
        end else begin
            n4_status = ST_HIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
            r5_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_a  <= DW'(x1) - DW'(x2);
            r1_b  <= DW'(y3) - DW'(y4);
            r1_c  <= DW'(y1) - DW'(y2);
            r1_e  <= DW'(x3) - DW'(x4);
            r1_f  <= DW'(x1) - DW'(x3);
            r1_g  <= DW'(y1) - DW'(y3);
            r1_dx <= DW'(x2) - DW'(x1);
            r1_dy <= DW'(y2) - DW'(y1);
            r1_x1 <= x1;
            r1_y1 <= y1;

            r2_ab <= r1_a * r1_b;
            r2_ce <= r1_c * r1_e;
            r2_fb <= r1_f * r1_b;
            r2_ge <= r1_g * r1_e;
            r2_ag <= r1_a * r1_g;
            r2_cf <= r1_c * r1_f;
            r2_dx <= r1_dx;
            r2_dy <= r1_dy;
            r2_x1 <= r1_x1;
            r2_y1 <= r1_y1;

            r3_d  <= KW'(r2_ab) - KW'(r2_ce);
            r3_tn <= KW'(r2_fb) - KW'(r2_ge);
            r3_un <= KW'(r2_cf) - KW'(r2_ag);
            r3_dx <= r2_dx;
            r3_dy <= r2_dy;
            r3_x1 <= r2_x1;
            r3_y1 <= r2_y1;

            r4_den           <= MW'(n4_d);
            r4_tn            <= MW'(n4_tn);
            r4_mag_x         <= COORD_BITS'(n4_mx);
            r4_mag_y         <= COORD_BITS'(n4_my);
            r4_side.status   <= n4_status;
            r4_side.neg_x    <= r3_dx[DW-1];
            r4_side.neg_y    <= r3_dy[DW-1];
            r4_side.base_x   <= r3_x1;
            r4_side.base_y   <= r3_y1;

            r5_num_x <= NW'(r4_tn) * NW'(r4_mag_x);
            r5_num_y <= NW'(r4_tn) * NW'(r4_mag_y);
            r5_den   <= r4_den;
            r5_side  <= r4_side;
        end
    end

    assign o_valid = r5_valid;
    assign o_num_x = r5_num_x;
    assign o_num_y = r5_num_y;
    assign o_den   = r5_den;
    assign o_side  = r5_side;

endmodule

FILE: hw/rtl/si_divider.sv
// ============================================================================
// si_divider - pipelined restoring divider for both coordinates
// One quotient bit per stage for x and y, sharing the divisor.
// ============================================================================
module si_divider
    import si_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  logic [NW-1:0]  i_num_x,
    input  logic [NW-1:0]  i_num_y,
    input  logic [MW-1:0]  i_den,
    input  t_side          i_side,
    output logic           o_valid,
    output logic [QW-1:0]  o_q_x,
    output logic [QW-1:0]  o_q_y,
    output logic           o_exact_x,
    output logic           o_exact_y,
    output t_side          o_side
);

    logic [DVW-1:0] dv_x, dv_y;

    logic           r_valid [QW];
    logic [MW-1:0]  r_rem_x [QW];
    logic [MW-1:0]  r_rem_y [QW];
    logic [QW-1:0]  r_low_x [QW];
    logic [QW-1:0]  r_low_y [QW];
    logic [QW-1:0]  r_q_x   [QW];
    logic [QW-1:0]  r_q_y   [QW];
    logic [MW-1:0]  r_den   [QW];
    t_side          r_side  [QW];

    assign dv_x = DVW'(i_num_x) << FRAC_BITS;
    assign dv_y = DVW'(i_num_y) << FRAC_BITS;

    for (genvar s = 0; s < QW; s++) begin : g_stage
        logic          p_valid;
        logic [MW-1:0] p_rem_x, p_rem_y, p_den;
        logic [QW-1:0] p_low_x, p_low_y, p_q_x, p_q_y;
        t_side         p_side;
        logic [RW-1:0] t_x, t_y;
        logic          ge_x, ge_y;

        if (s == 0) begin : g_first
            assign p_valid = i_valid;
            assign p_rem_x = MW'(dv_x >> QW);
            assign p_rem_y = MW'(dv_y >> QW);
            assign p_low_x = dv_x[QW-1:0];
            assign p_low_y = dv_y[QW-1:0];
            assign p_q_x   = '0;
            assign p_q_y   = '0;
            assign p_den   = i_den;
            assign p_side  = i_side;
        end else begin : g_next
            assign p_valid = r_valid[s-1];
            assign p_rem_x = r_rem_x[s-1];
            assign p_rem_y = r_rem_y[s-1];
            assign p_low_x = r_low_x[s-1];
            assign p_low_y = r_low_y[s-1];
            assign p_q_x   = r_q_x[s-1];
            assign p_q_y   = r_q_y[s-1];
            assign p_den   = r_den[s-1];
            assign p_side  = r_side[s-1];
        end

        // shift in the next dividend bit, subtract when it fits
        assign t_x  = {p_rem_x, p_low_x[QW-1]};
        assign t_y  = {p_rem_y, p_low_y[QW-1]};
        assign ge_x = t_x >= RW'(p_den);
        assign ge_y = t_y >= RW'(p_den);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else if (i_en) begin
                r_valid[s] <= p_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem_x[s] <= MW'(ge_x ? t_x - RW'(p_den) : t_x);
                r_rem_y[s] <= MW'(ge_y ? t_y - RW'(p_den) : t_y);
                r_low_x[s] <= p_low_x << 1;
                r_low_y[s] <= p_low_y << 1;
                r_q_x[s]   <= {p_q_x[QW-2:0], ge_x};
                r_q_y[s]   <= {p_q_y[QW-2:0], ge_y};
                r_den[s]   <= p_den;
                r_side[s]  <= p_side;
            end
        end
    end

    assign o_valid   = r_valid[QW-1];
    assign o_q_x     = r_q_x[QW-1];
    assign o_q_y     = r_q_y[QW-1];
    assign o_exact_x = r_rem_x[QW-1] == '0;
    assign o_exact_y = r_rem_y[QW-1] == '0;
    assign o_side    = r_side[QW-1];

endmodule

FILE: hw/rtl/segment_intersection.sv
// ============================================================================
// segment_intersection - 2D line segment intersection, pipelined
// Determinant, bounds test and Q16.16 crossing point of two segments.
// ============================================================================
// Usage:
//   Slave stream: one beat carries both segments, eight signed coordinates.
//   Master stream: one beat per input beat, in order; tuser holds the status
//   (hit, parallel, outside), tdata the crossing point, zero unless hit.
//   Pipeline: from accepted input beat to valid output beat there are five
//   front stages, one divider stage per quotient bit, one output register.
//   Throughput: one beat per cycle while the skid entry is free; the divider
//   is fully pipelined, one restoring step per stage.
//   Reset: synchronous, active low; clears all valid bits, the pipeline is
//   empty and ready right after reset.
//   Stall: an output register plus a one-entry skid buffer; the pipeline
//   keeps accepting while the output register waits. Once the skid entry
//   fills, the whole pipeline holds and tready drops until the receiver
//   takes a beat. No beat is dropped or repeated.
// ============================================================================
module segment_intersection
    import si_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // first_start_x, first_start_y, first_end_x, first_end_y,
    // second_start_x, second_start_y, second_end_x, second_end_y
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // cross_x, cross_y
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    // status
    output logic [1:0]             o_m_axis_tuser
);

    logic          en;
    logic          f_valid;
    logic [NW-1:0] f_num_x, f_num_y;
    logic [MW-1:0] f_den;
    t_side         f_side;

    logic          d_valid;
    logic [QW-1:0] d_q_x, d_q_y;
    logic          d_exact_x, d_exact_y;
    t_side         d_side;

    t_result       n_res;
    logic          r_out_valid, r_skid_valid;
    t_result       r_out, r_skid;
    logic          take;

    // advance the whole pipeline whenever the skid entry is free
    assign en              = !r_skid_valid;
    assign o_s_axis_tready = en;

    si_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_s_axis_tvalid),
        .i_tdata (i_s_axis_tdata),
        .o_valid (f_valid),
        .o_num_x (f_num_x),
        .o_num_y (f_num_y),
        .o_den   (f_den),
        .o_side  (f_side)
    );

    si_divider u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (f_valid),
        .i_num_x   (f_num_x),
        .i_num_y   (f_num_y),
        .i_den     (f_den),
        .i_side    (f_side),
        .o_valid   (d_valid),
        .o_q_x     (d_q_x),
        .o_q_y     (d_q_y),
        .o_exact_x (d_exact_x),
        .o_exact_y (d_exact_y),
        .o_side    (d_side)
    );

    // Rebuild base + t * delta from the magnitude quotient. A negative delta
    // gives the floor of the signed offset; then round toward zero when the
    // sum is negative and the division left a remainder.
    function automatic logic [OUT_W-1:0] fix_coord(
        input logic signed [COORD_BITS-1:0] base,
        input logic                         neg,
        input logic [QW-1:0]                q,
        input logic                         exact
    );
        logic signed [VW-1:0] base_f;
        logic signed [VW-1:0] off;
        logic signed [VW-1:0] v;
        base_f = VW'(base) <<< FRAC_BITS;
        off    = neg ? -VW'(q) - VW'(!exact) : VW'(q);
        v      = base_f + off;
        if (v < 0 && !exact) begin
            v = v + VW'(1);
        end
        return OUT_W'(v);
    endfunction

    always_comb begin
        n_res.status  = d_side.status;
        n_res.cross_x = '0;
        n_res.cross_y = '0;
        if (d_side.status == ST_HIT) begin
            n_res.cross_x = fix_coord(d_side.base_x, d_side.neg_x, d_q_x, d_exact_x);
            n_res.cross_y = fix_coord(d_side.base_y, d_side.neg_y, d_q_y, d_exact_y);
        end
    end

    assign take = r_out_valid && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (en && d_valid) begin
            // skid entry is empty here; land in the output register or park
            if (!r_out_valid || take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (take) begin
            // refill from the skid entry, or drain
            r_out_valid  <= r_skid_valid;
            r_skid_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && r_skid_valid) begin
            r_out <= r_skid;
        end
        if (en && d_valid) begin
            if (!r_out_valid || take) begin
                r_out <= n_res;
            end else begin
                r_skid <= n_res;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out.cross_y, r_out.cross_x};
    assign o_m_axis_tuser  = r_out.status;

endmodule
